// ----- rtl/smsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsc_pkg: shared types and constants for the SPI master/slave controller
// Holds the step kinds, register indexes, configuration and result records.
// ----------------------------------------------------------------------------
package smsc_pkg;

    // Kind of one input word
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CPOL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CPHA       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SEL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_ENABLE = 3'd6;

    localparam int                    RATE_W        = 3;
    localparam logic [RATE_W-1:0]     RATE_SEL_MAX  = 3'd6;
    localparam logic [RATE_W-1:0]     RATE_SEL_RST  = 3'd1;
    localparam int                    DIV_W         = 7;
    localparam int                    BYTE_W        = 8;

    typedef struct packed {
        logic              enable;
        logic              master_mode;
        logic              lsb_first;
        logic              clock_polarity;
        logic              clock_phase;
        logic [RATE_W-1:0] rate_select;
        logic              irq_enable;
    } t_cfg;

    typedef struct packed {
        logic              sck_out;
        logic              mosi_out;
        logic              miso_out;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_flag;
        logic              busy_res;
        logic              irq;
    } t_result;

endpackage

// ----- rtl/smsc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsc_cfg_regs: configuration register file
// Seven control registers written through a plain index/data write port.
// ----------------------------------------------------------------------------
module smsc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [smsc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output smsc_pkg::t_cfg                   o_cfg
);

    smsc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b0;
            r_cfg.master_mode    <= 1'b0;
            r_cfg.lsb_first      <= 1'b0;
            r_cfg.clock_polarity <= 1'b0;
            r_cfg.clock_phase    <= 1'b0;
            r_cfg.rate_select    <= smsc_pkg::RATE_SEL_RST;
            r_cfg.irq_enable     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                smsc_pkg::REG_ENABLE:     r_cfg.enable         <= i_cfg_wdata[0];
                smsc_pkg::REG_MASTER:     r_cfg.master_mode    <= i_cfg_wdata[0];
                smsc_pkg::REG_LSB_FIRST:  r_cfg.lsb_first      <= i_cfg_wdata[0];
                smsc_pkg::REG_CPOL:       r_cfg.clock_polarity <= i_cfg_wdata[0];
                smsc_pkg::REG_CPHA:       r_cfg.clock_phase    <= i_cfg_wdata[0];
                smsc_pkg::REG_RATE_SEL:   r_cfg.rate_select    <= i_cfg_wdata[smsc_pkg::RATE_W-1:0];
                smsc_pkg::REG_IRQ_ENABLE: r_cfg.irq_enable     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/smsc_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsc_engine: SPI shift engine state and next-state logic
// Holds shifter, bit counter, divider and flags; computes one step per word.
// ----------------------------------------------------------------------------
module smsc_engine #(
    parameter int DATA_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  smsc_pkg::t_cfg                  i_cfg,
    input  smsc_pkg::t_kind                 i_kind,
    input  logic [smsc_pkg::BYTE_W-1:0]     i_tx_byte,
    input  logic                            i_miso_in,
    input  logic                            i_mosi_in,
    input  logic                            i_sck_in,
    input  logic                            i_ss_n_in,
    output smsc_pkg::t_result               o_res
);

    localparam int CNT_W = $clog2(DATA_BITS + 1);

    logic [DATA_BITS-1:0]           r_shift, n_shift;
    logic [CNT_W-1:0]               r_bit_cnt, n_bit_cnt;
    logic [smsc_pkg::DIV_W-1:0]     r_div_cnt, n_div_cnt;
    logic                           r_sck_level, n_sck_level;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [smsc_pkg::BYTE_W-1:0]    r_rx_hold, n_rx_hold;
    logic                           r_prev_sck, n_prev_sck;
    logic                           r_sample, n_sample;

    logic                           w_edge;
    logic                           w_lead;
    logic                           w_edge_in;
    logic [smsc_pkg::RATE_W-1:0]    w_rate;
    logic [smsc_pkg::DIV_W-1:0]     w_half;
    logic [smsc_pkg::DIV_W-1:0]     w_div_inc;
    logic                           w_out_bit;

    function automatic logic [DATA_BITS-1:0] f_shift_in(
        input logic [DATA_BITS-1:0] s,
        input logic                 b,
        input logic                 lsb
    );
        return lsb ? {b, s[DATA_BITS-1:1]} : {s[DATA_BITS-2:0], b};
    endfunction

    assign w_rate    = (i_cfg.rate_select > smsc_pkg::RATE_SEL_MAX) ?
                       smsc_pkg::RATE_SEL_MAX : i_cfg.rate_select;
    assign w_half    = smsc_pkg::DIV_W'(1) << w_rate;
    assign w_div_inc = r_div_cnt + smsc_pkg::DIV_W'(1);

    always_comb begin
        n_shift     = r_shift;
        n_bit_cnt   = r_bit_cnt;
        n_div_cnt   = r_div_cnt;
        n_sck_level = r_sck_level;
        n_busy      = r_busy;
        n_done      = r_done;
        n_rx_hold   = r_rx_hold;
        n_prev_sck  = r_prev_sck;
        n_sample    = r_sample;
        w_edge      = 1'b0;
        w_lead      = 1'b0;
        w_edge_in   = 1'b0;

        case (i_kind)
            smsc_pkg::KIND_TICK: begin
                if (!i_cfg.enable) begin
                    n_busy      = 1'b0;
                    n_bit_cnt   = '0;
                    n_div_cnt   = '0;
                    n_sck_level = i_cfg.clock_polarity;
                end else if (i_cfg.master_mode) begin
                    if (r_busy) begin
                        if (w_div_inc >= w_half) begin
                            n_div_cnt   = '0;
                            n_sck_level = ~r_sck_level;
                            w_edge      = 1'b1;
                            w_lead      = (r_sck_level == i_cfg.clock_polarity);
                            w_edge_in   = i_miso_in;
                        end else begin
                            n_div_cnt = w_div_inc;
                        end
                    end else begin
                        n_sck_level = i_cfg.clock_polarity;
                        n_div_cnt   = '0;
                    end
                end else begin
                    if (i_ss_n_in) begin
                        n_bit_cnt = '0;
                        n_busy    = 1'b0;
                    end else if (i_sck_in != r_prev_sck) begin
                        n_busy    = 1'b1;
                        w_edge    = 1'b1;
                        w_lead    = (r_prev_sck == i_cfg.clock_polarity);
                        w_edge_in = i_mosi_in;
                    end
                end
                n_prev_sck = i_sck_in;
            end
            smsc_pkg::KIND_WRITE: begin
                if (i_cfg.enable && !r_busy) begin
                    n_shift   = DATA_BITS'(i_tx_byte);
                    n_sample  = 1'b0;
                    n_bit_cnt = '0;
                    if (i_cfg.master_mode) begin
                        n_busy      = 1'b1;
                        n_div_cnt   = '0;
                        n_sck_level = i_cfg.clock_polarity;
                    end
                end
            end
            smsc_pkg::KIND_READ: begin
                n_done = 1'b0;
            end
            default: ;
        endcase

        // Sampling edge latches the line; the opposite edge shifts it in
        if (w_edge) begin
            if (w_lead) begin
                if (!i_cfg.clock_phase) begin
                    n_sample = w_edge_in;
                end else if (n_bit_cnt != '0) begin
                    n_shift = f_shift_in(n_shift, n_sample, i_cfg.lsb_first);
                end
            end else begin
                if (!i_cfg.clock_phase) begin
                    n_shift = f_shift_in(n_shift, n_sample, i_cfg.lsb_first);
                end else begin
                    n_sample = w_edge_in;
                end
                n_bit_cnt = n_bit_cnt + CNT_W'(1);
                if (n_bit_cnt >= CNT_W'(DATA_BITS)) begin
                    if (i_cfg.clock_phase) begin
                        n_shift = f_shift_in(n_shift, n_sample, i_cfg.lsb_first);
                    end
                    n_busy    = 1'b0;
                    n_bit_cnt = '0;
                    n_div_cnt = '0;
                    n_done    = 1'b1;
                    n_rx_hold = n_shift[smsc_pkg::BYTE_W-1:0];
                end
            end
        end
    end

    assign w_out_bit = i_cfg.lsb_first ? n_shift[0] : n_shift[DATA_BITS-1];

    always_comb begin
        o_res.sck_out   = i_cfg.master_mode &
                          (n_busy ? n_sck_level : i_cfg.clock_polarity);
        o_res.mosi_out  = i_cfg.master_mode & w_out_bit;
        o_res.miso_out  = ~i_cfg.master_mode & ~i_ss_n_in & w_out_bit;
        o_res.rx_byte   = n_rx_hold;
        o_res.done_flag = n_done;
        o_res.busy_res  = n_busy;
        o_res.irq       = n_done & i_cfg.irq_enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_bit_cnt   <= '0;
            r_div_cnt   <= '0;
            r_sck_level <= 1'b0;
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_rx_hold   <= '0;
            r_prev_sck  <= 1'b0;
            r_sample    <= 1'b0;
        end else if (i_step) begin
            r_shift     <= n_shift;
            r_bit_cnt   <= n_bit_cnt;
            r_div_cnt   <= n_div_cnt;
            r_sck_level <= n_sck_level;
            r_busy      <= n_busy;
            r_done      <= n_done;
            r_rx_hold   <= n_rx_hold;
            r_prev_sck  <= n_prev_sck;
            r_sample    <= n_sample;
        end
    end

endmodule

// ----- rtl/spi_master_slave_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_slave_controller: 8-bit SPI master/slave peripheral
// Steps one tick, data write or data read per word and reports the status.
// ----------------------------------------------------------------------------
// Each accepted word (a system tick, a data write that starts a transfer, or
// a data read that clears the completion flag) produces exactly one result
// word, registered and presented on the cycle after acceptance. One word is
// taken every cycle: the engine updates its state in a single pass and the
// result register frees up as soon as its word is taken, so o_ready only
// drops while a result waits with i_ready low. Configuration writes are
// registered through the plain write port.
// ----------------------------------------------------------------------------
module spi_master_slave_controller #(
    parameter int DATA_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [smsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [smsc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input words
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_kind,
    input  logic [smsc_pkg::BYTE_W-1:0]       i_tx_byte,
    input  logic                              i_miso_in,
    input  logic                              i_mosi_in,
    input  logic                              i_sck_in,
    input  logic                              i_ss_n_in,
    // result words
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_sck_out,
    output logic                              o_mosi_out,
    output logic                              o_miso_out,
    output logic [smsc_pkg::BYTE_W-1:0]       o_rx_byte,
    output logic                              o_done_flag,
    output logic                              o_busy_res,
    output logic                              o_irq
);

    smsc_pkg::t_cfg    w_cfg;
    smsc_pkg::t_result w_res;
    smsc_pkg::t_result r_out;
    logic              r_out_valid;
    logic              w_accept;
    smsc_pkg::t_kind   w_kind;

    assign w_kind   = smsc_pkg::t_kind'(i_kind);
    assign o_ready  = ~r_out_valid | i_ready;
    assign w_accept = i_valid & o_ready;

    smsc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    smsc_engine #(
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_accept),
        .i_cfg     (w_cfg),
        .i_kind    (w_kind),
        .i_tx_byte (i_tx_byte),
        .i_miso_in (i_miso_in),
        .i_mosi_in (i_mosi_in),
        .i_sck_in  (i_sck_in),
        .i_ss_n_in (i_ss_n_in),
        .o_res     (w_res)
    );

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_sck_out   = r_out.sck_out;
    assign o_mosi_out  = r_out.mosi_out;
    assign o_miso_out  = r_out.miso_out;
    assign o_rx_byte   = r_out.rx_byte;
    assign o_done_flag = r_out.done_flag;
    assign o_busy_res  = r_out.busy_res;
    assign o_irq       = r_out.irq;

    a_read_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind == smsc_pkg::KIND_READ) |=> !o_done_flag)
        else $error("read did not clear completion flag");

    a_master_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind == smsc_pkg::KIND_WRITE && w_cfg.enable && w_cfg.master_mode)
        |=> o_busy_res)
        else $error("master write did not leave transfer busy");

    a_irq_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_irq || (o_done_flag && w_cfg.irq_enable) ||
                     $past(i_cfg_we)))
        else $error("interrupt raised without completion flag");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule
